[src/bear_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the button edge and auto-repeat block.
// No dependencies; every other file in src uses it.
package bear_pkg;

  localparam int LINE_COUNT      = 20;
  localparam int BTN_COUNT       = 16;
  localparam int HAT_COUNT       = 4;
  localparam int LINE_IDX_W      = $clog2(LINE_COUNT);
  localparam int STAMP_W         = 32;
  localparam int DELAY_W         = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 20;
  localparam int NUM_BUTTONS_DEF = 16;

  localparam logic [DELAY_W-1:0] DELAY_RST    = DELAY_W'(500);
  localparam logic [DELAY_W-1:0] INTERVAL_RST = DELAY_W'(100);

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DELAY       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL    = CFG_IDX_W'(2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } eng_state_t;

  typedef struct packed {
    logic [LINE_COUNT-1:0] enable_mask;
    logic [DELAY_W-1:0]    delay;
    logic [DELAY_W-1:0]    interval;
    logic                  rep_clr;
  } cfg_regs_t;

  typedef struct packed {
    logic                  rd_en;
    logic [LINE_IDX_W-1:0] rd_addr;
    logic                  wr_en;
    logic [LINE_IDX_W-1:0] wr_addr;
    logic [STAMP_W-1:0]    wr_data;
  } mem_req_t;

  // Buttons at or above the fitted count always read as up
  function automatic logic [BTN_COUNT-1:0] btn_mask(int n);
    logic [BTN_COUNT-1:0] m;
    for (int i = 0; i < BTN_COUNT; i++) begin
      m[i] = (i < n);
    end
    return m;
  endfunction

endpackage

[src/bear_in_if.sv]
`timescale 1ns / 1ps
// Input request channel: tick count, button and hat levels.
// Depends on bear_pkg for field widths.
interface bear_in_if;
  logic                              valid;
  logic                              ready;
  logic [bear_pkg::STAMP_W-1:0]      tick_now;
  logic [bear_pkg::BTN_COUNT-1:0]    button_bits;
  logic [bear_pkg::HAT_COUNT-1:0]    hat_bits;

  modport source (output valid, output tick_now, output button_bits, output hat_bits,
                  input ready);
  modport sink   (input valid, input tick_now, input button_bits, input hat_bits,
                  output ready);
endinterface

[src/bear_out_if.sv]
`timescale 1ns / 1ps
// Result channel: press, held, release and level vectors per line.
// Depends on bear_pkg for field widths.
interface bear_out_if;
  logic                              valid;
  logic                              ready;
  logic [bear_pkg::LINE_COUNT-1:0]   press_events;
  logic [bear_pkg::LINE_COUNT-1:0]   held_lines;
  logic [bear_pkg::LINE_COUNT-1:0]   release_events;
  logic [bear_pkg::LINE_COUNT-1:0]   level_lines;

  modport source (output valid, output press_events, output held_lines,
                  output release_events, output level_lines, input ready);
  modport sink   (input valid, input press_events, input held_lines,
                  input release_events, input level_lines, output ready);
endinterface

[src/bear_cfg_if.sv]
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Depends on bear_pkg for field widths.
interface bear_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bear_pkg::CFG_IDX_W-1:0]    index;
  logic [bear_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[src/button_edge_auto_repeat.sv]
`timescale 1ns / 1ps
// Channel  Dir   Handshake      Payload
// in_ch    in    valid/ready    tick_now, button_bits, hat_bits
// out_ch   out   valid/ready    press_events, held_lines, release_events, level_lines
// cfg_ch   in    valid/ready    index, data (0 enable mask, 1 delay, 2 interval)
//
// Each request is accepted with the first stamp read issued, then the 20 lines are walked in
// turn through the separate read and write ports of the stamp store, and then the result
// register is loaded. A finished result waits in its register while the next request
// is taken. Reset (synchronous, rst_n low) clears levels, stamp valid bits, repeated
// flags and registers at once; no clearing pass. Configuration is always ready.
module button_edge_auto_repeat #(
  parameter int NUM_BUTTONS = bear_pkg::NUM_BUTTONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bear_in_if.sink     in_ch,
  bear_out_if.source  out_ch,
  bear_cfg_if.sink    cfg_ch
);

  bear_pkg::cfg_regs_t          cfg;
  bear_pkg::mem_req_t           mem_req;
  logic [bear_pkg::STAMP_W-1:0] mem_rd_data;

  bear_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  bear_stamp_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  bear_line_eng #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_eng (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg         (cfg),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data)
  );

endmodule

[src/bear_cfg_regs.sv]
`timescale 1ns / 1ps
// Configuration registers: enable mask, first-repeat delay, repeat interval.
// Depends on bear_pkg and bear_cfg_if.
module bear_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  bear_cfg_if.sink            cfg_ch,
  output bear_pkg::cfg_regs_t cfg
);

  logic [bear_pkg::LINE_COUNT-1:0] mask_r, mask_nxt;
  logic [bear_pkg::DELAY_W-1:0]    delay_r, delay_nxt;
  logic [bear_pkg::DELAY_W-1:0]    interval_r, interval_nxt;
  logic                            clr_r, clr_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    mask_nxt     = mask_r;
    delay_nxt    = delay_r;
    interval_nxt = interval_r;
    clr_nxt      = 1'b0;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        bear_pkg::REG_ENABLE_MASK: begin
          mask_nxt = cfg_ch.data[bear_pkg::LINE_COUNT-1:0];
          clr_nxt  = 1'b1;
        end
        bear_pkg::REG_DELAY:    delay_nxt    = cfg_ch.data[bear_pkg::DELAY_W-1:0];
        bear_pkg::REG_INTERVAL: interval_nxt = cfg_ch.data[bear_pkg::DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r     <= '0;
      delay_r    <= bear_pkg::DELAY_RST;
      interval_r <= bear_pkg::INTERVAL_RST;
      clr_r      <= 1'b0;
    end else begin
      mask_r     <= mask_nxt;
      delay_r    <= delay_nxt;
      interval_r <= interval_nxt;
      clr_r      <= clr_nxt;
    end
  end

  // a mask write sets the registered clear strobe rep_clr, which clears the engine's repeated flags
  assign cfg.enable_mask = mask_r;
  assign cfg.delay       = delay_r;
  assign cfg.interval    = interval_r;
  assign cfg.rep_clr     = clr_r;

endmodule

[src/bear_stamp_mem.sv]
`timescale 1ns / 1ps
// Press stamp store: one 32-bit tick per line, one write and one read port.
// Read data registered. Depends on bear_pkg.
module bear_stamp_mem (
  input  logic                           clk,
  input  bear_pkg::mem_req_t             req,
  output logic [bear_pkg::STAMP_W-1:0]   rd_data
);

  logic [bear_pkg::STAMP_W-1:0] mem [bear_pkg::LINE_COUNT];
  logic [bear_pkg::STAMP_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/bear_line_eng.sv]
`timescale 1ns / 1ps
// Line engine: walks the lines one per cycle, reading the press stamp,
// deciding the event and writing the stamp back. Depends on bear_pkg and the interfaces.
module bear_line_eng #(
  parameter int NUM_BUTTONS = bear_pkg::NUM_BUTTONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bear_in_if.sink                       in_ch,
  bear_out_if.source                    out_ch,
  input  bear_pkg::cfg_regs_t           cfg,
  output bear_pkg::mem_req_t            mem_req,
  input  logic [bear_pkg::STAMP_W-1:0]  mem_rd_data
);

  localparam int LC = bear_pkg::LINE_COUNT;
  localparam int IW = bear_pkg::LINE_IDX_W;
  localparam int SW = bear_pkg::STAMP_W;
  localparam logic [bear_pkg::BTN_COUNT-1:0] BTN_MASK = bear_pkg::btn_mask(NUM_BUTTONS);
  localparam logic [IW-1:0] LAST_IDX = IW'(LC - 1);

  bear_pkg::eng_state_t state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [LC-1:0] last_lev_r, last_lev_nxt;
  logic [LC-1:0] stamp_vld_r, stamp_vld_nxt;
  logic [LC-1:0] has_rep_r, has_rep_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [SW-1:0] tick_r, tick_nxt;
  logic [LC-1:0] lev_r, lev_nxt;
  logic [LC-1:0] press_acc_r, press_acc_nxt;
  logic [LC-1:0] held_acc_r, held_acc_nxt;
  logic [LC-1:0] rel_acc_r, rel_acc_nxt;
  logic [LC-1:0] out_press_r, out_press_nxt;
  logic [LC-1:0] out_held_r, out_held_nxt;
  logic [LC-1:0] out_rel_r, out_rel_nxt;
  logic [LC-1:0] out_lev_r, out_lev_nxt;

  logic [LC-1:0]                in_levels;
  logic                         prev, curr, rep, fire;
  logic [SW-1:0]                stamp, elapsed;
  logic [bear_pkg::DELAY_W-1:0] limit;

  assign in_levels = {in_ch.hat_bits, in_ch.button_bits & BTN_MASK};
  assign in_ch.ready = (state_r == bear_pkg::ST_IDLE);

  // Per-line decision on the stamp just read
  assign prev    = last_lev_r[idx_r];
  assign curr    = lev_r[idx_r];
  assign rep     = has_rep_r[idx_r];
  assign stamp   = stamp_vld_r[idx_r] ? mem_rd_data : '0;
  assign limit   = rep ? cfg.interval : cfg.delay;
  assign elapsed = tick_r - stamp;
  assign fire    = cfg.enable_mask[idx_r] &&
                   (elapsed >= {{(SW - bear_pkg::DELAY_W){1'b0}}, limit});

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    last_lev_nxt  = last_lev_r;
    stamp_vld_nxt = stamp_vld_r;
    has_rep_nxt   = has_rep_r;
    out_valid_nxt = out_valid_r;
    tick_nxt      = tick_r;
    lev_nxt       = lev_r;
    press_acc_nxt = press_acc_r;
    held_acc_nxt  = held_acc_r;
    rel_acc_nxt   = rel_acc_r;
    out_press_nxt = out_press_r;
    out_held_nxt  = out_held_r;
    out_rel_nxt   = out_rel_r;
    out_lev_nxt   = out_lev_r;
    mem_req       = '0;
    mem_req.wr_addr = idx_r;
    mem_req.wr_data = tick_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      bear_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          tick_nxt      = in_ch.tick_now;
          lev_nxt       = in_levels;
          press_acc_nxt = '0;
          held_acc_nxt  = '0;
          rel_acc_nxt   = '0;
          idx_nxt       = '0;
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = '0;
          state_nxt     = bear_pkg::ST_SCAN;
        end
      end
      bear_pkg::ST_SCAN: begin
        if (!prev && curr) begin
          mem_req.wr_en         = 1'b1;
          stamp_vld_nxt[idx_r]  = 1'b1;
          press_acc_nxt[idx_r]  = 1'b1;
        end else if (prev && curr) begin
          if (fire) begin
            mem_req.wr_en        = 1'b1;
            stamp_vld_nxt[idx_r] = 1'b1;
            has_rep_nxt[idx_r]   = 1'b1;
            press_acc_nxt[idx_r] = 1'b1;
          end else begin
            held_acc_nxt[idx_r]  = 1'b1;
          end
        end else if (prev && !curr) begin
          has_rep_nxt[idx_r] = 1'b0;
          rel_acc_nxt[idx_r] = 1'b1;
        end
        // fetch the next line while this one is written back
        if (idx_r == LAST_IDX) begin
          state_nxt = bear_pkg::ST_DONE;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = idx_r + 1'b1;
          idx_nxt         = idx_r + 1'b1;
        end
      end
      bear_pkg::ST_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || out_ch.ready) begin
          out_press_nxt = press_acc_r;
          out_held_nxt  = held_acc_r;
          out_rel_nxt   = rel_acc_r;
          out_lev_nxt   = lev_r;
          out_valid_nxt = 1'b1;
          last_lev_nxt  = lev_r;
          state_nxt     = bear_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bear_pkg::ST_IDLE;
    endcase

    if (cfg.rep_clr) begin
      has_rep_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bear_pkg::ST_IDLE;
      idx_r       <= '0;
      last_lev_r  <= '0;
      stamp_vld_r <= '0;
      has_rep_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      last_lev_r  <= last_lev_nxt;
      stamp_vld_r <= stamp_vld_nxt;
      has_rep_r   <= has_rep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tick_r      <= tick_nxt;
    lev_r       <= lev_nxt;
    press_acc_r <= press_acc_nxt;
    held_acc_r  <= held_acc_nxt;
    rel_acc_r   <= rel_acc_nxt;
    out_press_r <= out_press_nxt;
    out_held_r  <= out_held_nxt;
    out_rel_r   <= out_rel_nxt;
    out_lev_r   <= out_lev_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.press_events   = out_press_r;
  assign out_ch.held_lines     = out_held_r;
  assign out_ch.release_events = out_rel_r;
  assign out_ch.level_lines    = out_lev_r;

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for button_edge_auto_repeat: directed table, then random phases.
// Depends on bear_pkg and the bear_in_if, bear_out_if and bear_cfg_if interfaces in src.
module tb;
  import bear_pkg::*;

  localparam int                   FITTED      = NUM_BUTTONS_DEF;
  localparam logic [BTN_COUNT-1:0] FITTED_MASK =
      (FITTED >= BTN_COUNT) ? '1 : BTN_COUNT'((1 << FITTED) - 1);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE   = CFG_IDX_W'(3);
  localparam int                   QUIET_LIMIT = 1000;
  localparam int                   DRAIN_WAIT  = 30;

  typedef struct packed {
    logic [LINE_COUNT-1:0] press_ev;
    logic [LINE_COUNT-1:0] held;
    logic [LINE_COUNT-1:0] rel_ev;
    logic [LINE_COUNT-1:0] level;
  } line_report_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [STAMP_W-1:0]    tick;
    logic [BTN_COUNT-1:0]  btn;
    logic [HAT_COUNT-1:0]  hat;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  known;
    line_report_t          want;
  } plan_row_t;

  logic clk;
  logic rst_n;

  bear_in_if  in_ch ();
  bear_out_if out_ch ();
  bear_cfg_if cfg_ch ();

  button_edge_auto_repeat dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Shadow of the block's registers and per-line state
  logic [LINE_COUNT-1:0] en_mask;
  logic [DELAY_W-1:0]    rpt_delay;
  logic [DELAY_W-1:0]    rpt_interval;
  logic [LINE_COUNT-1:0] prev_levels;
  logic [STAMP_W-1:0]    stamp [LINE_COUNT];
  logic [LINE_COUNT-1:0] rep_flags;

  line_report_t due_reports [$];
  plan_row_t    plan [$];
  line_report_t seen;
  int           errors;
  int           quiet;
  bit           idle_on;
  logic [STAMP_W-1:0]    tick_cur;
  logic [LINE_COUNT-1:0] lvl_cur;

  function automatic line_report_t scan_lines(logic [STAMP_W-1:0] tick,
                                              logic [BTN_COUNT-1:0] btn,
                                              logic [HAT_COUNT-1:0] hat);
    line_report_t          r;
    logic [LINE_COUNT-1:0] lv;
    logic [STAMP_W-1:0]    elapsed;
    logic [STAMP_W-1:0]    lim;
    lv = {hat, btn & FITTED_MASK};
    r = '0;
    for (int i = 0; i < LINE_COUNT; i++) begin
      if (!prev_levels[i] && lv[i]) begin
        stamp[i] = tick;
        r.press_ev[i] = 1'b1;
      end else if (prev_levels[i] && lv[i]) begin
        elapsed = tick - stamp[i];
        lim = rep_flags[i] ? STAMP_W'(rpt_interval) : STAMP_W'(rpt_delay);
        if (en_mask[i] && elapsed >= lim) begin
          stamp[i] = tick;
          rep_flags[i] = 1'b1;
          r.press_ev[i] = 1'b1;
        end else begin
          r.held[i] = 1'b1;
        end
      end else if (prev_levels[i] && !lv[i]) begin
        rep_flags[i] = 1'b0;
        r.rel_ev[i] = 1'b1;
      end
    end
    prev_levels = lv;
    r.level = lv;
    return r;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_ENABLE_MASK: begin
        en_mask = val[LINE_COUNT-1:0];
        rep_flags = '0;
      end
      REG_DELAY:    rpt_delay = val[DELAY_W-1:0];
      REG_INTERVAL: rpt_interval = val[DELAY_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic plan_row_t row_item(logic [STAMP_W-1:0] tick, logic [BTN_COUNT-1:0] btn,
                                         logic [HAT_COUNT-1:0] hat);
    plan_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.tick = tick;
    r.btn = btn;
    r.hat = hat;
    return r;
  endfunction

  function automatic plan_row_t row_seen(logic [STAMP_W-1:0] tick, logic [BTN_COUNT-1:0] btn,
                                         logic [HAT_COUNT-1:0] hat, logic [19:0] p,
                                         logic [19:0] h, logic [19:0] rl, logic [19:0] l);
    plan_row_t r;
    r = row_item(tick, btn, hat);
    r.known = 1'b1;
    r.want = '{p, h, rl, l};
    return r;
  endfunction

  function automatic plan_row_t row_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    plan_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  // Every driving task starts and ends on a falling edge
  task automatic drive_item(input logic [STAMP_W-1:0] tick, input logic [BTN_COUNT-1:0] btn,
                            input logic [HAT_COUNT-1:0] hat, input logic known,
                            input line_report_t want);
    int           gap;
    line_report_t got;
    cfg_ch.valid <= 1'b0;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.tick_now    <= tick;
    in_ch.button_bits <= btn;
    in_ch.hat_bits    <= hat;
    do @(posedge clk); while (!in_ch.ready);
    got = scan_lines(tick, btn, hat);
    due_reports.push_back(known ? want : got);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    // hold off until every outstanding request has produced its result
    in_ch.valid <= 1'b0;
    while (due_reports.size() != 0) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [LINE_COUNT-1:0] mask, input logic [DELAY_W-1:0] dly,
                           input logic [DELAY_W-1:0] ivl, input int step_max,
                           input bit gaps, input int count);
    logic [LINE_COUNT-1:0] flips;
    int                    r;
    write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    write_reg(REG_ENABLE_MASK, mask);
    write_reg(REG_DELAY, {4'($urandom), dly});
    write_reg(REG_INTERVAL, {4'($urandom), ivl});
    idle_on = gaps;
    // start some phases just short of the tick wrap
    if ($urandom_range(0, 2) == 0) tick_cur = 32'hFFFF_FFFF - $urandom_range(0, 4 * step_max);
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 70) tick_cur += $urandom_range(0, step_max);
      else if (r < 90) tick_cur += $urandom_range(0, 3 * step_max);
      else if (r < 96) tick_cur = $urandom;
      r = $urandom_range(0, 99);
      if (r < 10) begin
        lvl_cur = LINE_COUNT'($urandom);
      end else if (r < 85) begin
        flips = LINE_COUNT'($urandom & $urandom & $urandom & $urandom);
        lvl_cur ^= flips;
      end
      drive_item(tick_cur, lvl_cur[BTN_COUNT-1:0], lvl_cur[LINE_COUNT-1:BTN_COUNT], 1'b0, '0);
    end
  endtask

  // Result side: random back-pressure
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_reports.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected (levels %05h)",
                                  out_ch.level_lines));
      end else begin
        seen = due_reports.pop_front();
        if (out_ch.press_events !== seen.press_ev)
          report_mismatch($sformatf("press_events %05h, want %05h",
                                    out_ch.press_events, seen.press_ev));
        if (out_ch.held_lines !== seen.held)
          report_mismatch($sformatf("held_lines %05h, want %05h",
                                    out_ch.held_lines, seen.held));
        if (out_ch.release_events !== seen.rel_ev)
          report_mismatch($sformatf("release_events %05h, want %05h",
                                    out_ch.release_events, seen.rel_ev));
        if (out_ch.level_lines !== seen.level)
          report_mismatch($sformatf("level_lines %05h, want %05h",
                                    out_ch.level_lines, seen.level));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    errors = 0;
    quiet = 0;
    idle_on = 1'b1;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.tick_now = '0;
    in_ch.button_bits = '0;
    in_ch.hat_bits = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    en_mask = '0;
    rpt_delay = DELAY_RST;
    rpt_interval = INTERVAL_RST;
    prev_levels = '0;
    rep_flags = '0;
    for (int i = 0; i < LINE_COUNT; i++) stamp[i] = '0;

    // Reset registers: nothing enabled, so held lines never repeat
    plan.push_back(row_seen(32'd0, 16'h0000, 4'h0, 20'h0, 20'h0, 20'h0, 20'h0));
    plan.push_back(row_seen(32'd1, 16'hFFFF, 4'hF, 20'hFFFFF, 20'h0, 20'h0, 20'hFFFFF));
    plan.push_back(row_seen(32'd1000, 16'hFFFF, 4'hF, 20'h0, 20'hFFFFF, 20'h0, 20'hFFFFF));
    plan.push_back(row_seen(32'd1001, 16'h0000, 4'h0, 20'h0, 20'h0, 20'hFFFFF, 20'h0));
    // Zero delay and interval: repeat on every tick, across the wrap
    plan.push_back(row_reg(REG_ENABLE_MASK, 20'hFFFFF));
    plan.push_back(row_reg(REG_DELAY, 20'h00000));
    plan.push_back(row_reg(REG_INTERVAL, 20'h00000));
    plan.push_back(row_seen(32'hFFFF_FFFF, 16'h0001, 4'h0, 20'h1, 20'h0, 20'h0, 20'h1));
    plan.push_back(row_item(32'd0, 16'h0001, 4'h0));
    plan.push_back(row_item(32'd0, 16'h0001, 4'h0));
    // Upper data bits of a delay write are dropped
    plan.push_back(row_reg(REG_DELAY, 20'hF000A));
    plan.push_back(row_reg(REG_INTERVAL, 20'hA0003));
    plan.push_back(row_item(32'd100, 16'h8001, 4'h1));
    plan.push_back(row_item(32'd105, 16'h8001, 4'h1));
    plan.push_back(row_item(32'd110, 16'h8001, 4'h1));
    plan.push_back(row_item(32'd112, 16'h8001, 4'h1));
    // Mask write clears the repeated flags; hat up becomes a disabled held line
    plan.push_back(row_reg(REG_ENABLE_MASK, 20'h0FFFF));
    plan.push_back(row_item(32'd113, 16'h8001, 4'h1));
    plan.push_back(row_item(32'd120, 16'h8001, 4'h1));
    plan.push_back(row_reg(REG_SPARE, 20'hFFFFF));
    plan.push_back(row_reg(REG_DELAY, 20'h0FFFF));
    plan.push_back(row_reg(REG_INTERVAL, 20'hFFFFF));
    plan.push_back(row_item(32'h0001_007F, 16'h8001, 4'h1));
    // Tick going backwards reads as a huge elapsed time
    plan.push_back(row_item(32'h0001_007E, 16'h8001, 4'h1));
    plan.push_back(row_item(32'h0001_0080, 16'h0000, 4'h0));
    plan.push_back(row_item(32'h0001_0081, 16'h5555, 4'hA));
    plan.push_back(row_item(32'h0001_0082, 16'hAAAA, 4'h5));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_WRITE)
        write_reg(plan[k].reg_idx, plan[k].reg_val);
      else
        drive_item(plan[k].tick, plan[k].btn, plan[k].hat, plan[k].known, plan[k].want);
    end

    tick_cur = 32'h0001_0082;
    lvl_cur = 20'h5AAAA;
    run_phase(20'hFFFFF, 16'd0, 16'd0, 3, 1'b1, 50);
    run_phase(LINE_COUNT'($urandom), DELAY_W'($urandom_range(1, 40)),
              DELAY_W'($urandom_range(1, 10)), 15, 1'b1, 60);
    run_phase(20'hFFFFF, 16'hFFFF, 16'hFFFF, 30000, 1'b0, 50);
    run_phase(LINE_COUNT'($urandom), DELAY_RST, INTERVAL_RST, 120, 1'b1, 60);
    run_phase(20'h00000, DELAY_W'($urandom), DELAY_W'($urandom), 50, 1'b1, 40);
    run_phase(20'hFFFFF, 16'd0, 16'hFFFF, 20000, 1'b1, 50);
    run_phase(LINE_COUNT'($urandom), DELAY_W'($urandom_range(0, 60)),
              DELAY_W'($urandom_range(0, 20)), 20, 1'b1, 60);

    in_ch.valid <= 1'b0;
    cfg_ch.valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
